@@ rtl/tlbrr_pkg.sv @@
// shared types and constants for the round-robin tlb fill / invalidate unit
// no dependencies; imported by tlbrr_cell and the top level

package tlbrr_pkg;

    localparam int PAGE_BITS = 20;
    localparam int SLOT_BITS = 6;

    localparam logic OP_INSERT     = 1'b0;
    localparam logic OP_INVALIDATE = 1'b1;

    typedef struct packed {
        logic                 op;
        logic [PAGE_BITS-1:0] virt_page;
        logic [PAGE_BITS-1:0] phys_page;
    } tlbrr_in_t;

    typedef struct packed {
        logic                 replaced;
        logic [SLOT_BITS-1:0] slot;
    } tlbrr_out_t;

    // what the chain is doing during one pass
    typedef enum logic [1:0] {
        MODE_FILL,
        MODE_FORCE,
        MODE_INVAL
    } tlbrr_mode_t;

    // broadcast to every cell for the whole pass
    typedef struct packed {
        tlbrr_mode_t          mode;
        logic [PAGE_BITS-1:0] vpage;
        logic [PAGE_BITS-1:0] frame;
    } tlbrr_cmd_t;

    // token handed from cell to cell
    typedef struct packed {
        logic active;
        logic done;
    } tlbrr_tok_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FORCE,
        ST_RESP
    } tlbrr_state_t;

endpackage

@@ rtl/tlb_fill_round_robin_invalidate_unit.sv @@
// top level of the round-robin tlb fill / invalidate unit
// depends on tlbrr_pkg and tlbrr_cell
//
//  channel   direction  payload       beat taken when
//  cmd       in         tlbrr_in_t    cmd_valid && cmd_ready
//  rsp       out        tlbrr_out_t   rsp_valid && rsp_ready
//
// one command at a time: a token walks the row of TLB_ENTRIES cells, one cell
// per cycle; a fill into a free slot or an invalidate needs one walk before the
// rsp beat is offered
// a fill with every slot valid needs a second walk to write the victim slot
// reset clears all valid flags, frames and the victim pointer at once
// the rsp register holds a finished beat while the next command is accepted;
// a stalled rsp only holds the unit once the following result is ready

module tlb_fill_round_robin_invalidate_unit
    import tlbrr_pkg::*;
#(
    parameter int TLB_ENTRIES = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cmd_valid,
    output logic       cmd_ready,
    input  tlbrr_in_t  cmd,
    output logic       rsp_valid,
    input  logic       rsp_ready,
    output tlbrr_out_t rsp
);

    localparam int IDX_W = (TLB_ENTRIES > 1) ? $clog2(TLB_ENTRIES) : 1;

    tlbrr_state_t     state_reg, state_next;
    logic             launch_reg, launch_next;
    tlbrr_cmd_t       cmd_reg, cmd_next;
    logic [IDX_W-1:0] victim_reg, victim_next;
    logic             res_replaced_reg, res_replaced_next;
    logic [IDX_W-1:0] res_slot_reg, res_slot_next;
    logic             rsp_valid_reg, rsp_valid_next;
    tlbrr_out_t       rsp_reg, rsp_next;

    // token chain, one stage per entry
    tlbrr_tok_t       tok_w  [0:TLB_ENTRIES];
    logic [IDX_W-1:0] slot_w [0:TLB_ENTRIES];
    tlbrr_tok_t       last_tok;
    logic [IDX_W-1:0] last_slot;

    assign tok_w[0].active = launch_reg;
    assign tok_w[0].done   = 1'b0;
    assign slot_w[0]       = '0;

    for (genvar gi = 0; gi < TLB_ENTRIES; gi++)
    begin : g_cell
        tlbrr_cell #(
            .IDX_W      (IDX_W),
            .CELL_INDEX (gi)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .cmd        (cmd_reg),
            .force_slot (victim_reg),
            .tok_in     (tok_w[gi]),
            .slot_in    (slot_w[gi]),
            .tok_out    (tok_w[gi+1]),
            .slot_out   (slot_w[gi+1])
        );
    end

    assign last_tok  = tok_w[TLB_ENTRIES];
    assign last_slot = slot_w[TLB_ENTRIES];

    always_comb
    begin
        state_next        = state_reg;
        launch_next       = 1'b0;
        cmd_next          = cmd_reg;
        victim_next       = victim_reg;
        res_replaced_next = res_replaced_reg;
        res_slot_next     = res_slot_reg;
        rsp_next          = rsp_reg;
        rsp_valid_next    = rsp_valid_reg;
        cmd_ready         = (state_reg == ST_IDLE);

        // downstream took the beat
        if (rsp_valid_reg && rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_next.mode  = (cmd.op == OP_INVALIDATE) ? MODE_INVAL : MODE_FILL;
                    cmd_next.vpage = cmd.virt_page;
                    cmd_next.frame = cmd.phys_page;
                    launch_next    = 1'b1;
                    state_next     = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (last_tok.active)
                begin
                    if ((cmd_reg.mode == MODE_FILL) && !last_tok.done)
                    begin
                        // table full: advance the victim pointer and walk again
                        victim_next   = (victim_reg == IDX_W'(TLB_ENTRIES - 1)) ?
                                        '0 : victim_reg + IDX_W'(1);
                        cmd_next.mode = MODE_FORCE;
                        launch_next   = 1'b1;
                        state_next    = ST_FORCE;
                    end
                    else
                    begin
                        res_replaced_next = 1'b0;
                        res_slot_next     = (cmd_reg.mode == MODE_FILL) ? last_slot : '0;
                        state_next        = ST_RESP;
                    end
                end
            end
            ST_FORCE:
            begin
                if (last_tok.active)
                begin
                    res_replaced_next = 1'b1;
                    res_slot_next     = victim_reg;
                    state_next        = ST_RESP;
                end
            end
            ST_RESP:
            begin
                if (!rsp_valid_reg || rsp_ready)
                begin
                    rsp_next.replaced = res_replaced_reg;
                    rsp_next.slot     = SLOT_BITS'(res_slot_reg);
                    rsp_valid_next    = 1'b1;
                    state_next        = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            launch_reg    <= 1'b0;
            victim_reg    <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            launch_reg    <= launch_next;
            victim_reg    <= victim_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        cmd_reg          <= cmd_next;
        res_replaced_reg <= res_replaced_next;
        res_slot_reg     <= res_slot_next;
        rsp_reg          <= rsp_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

@@ rtl/tlbrr_cell.sv @@
// one translation entry of the chain: valid flag, virtual page, frame
// depends on tlbrr_pkg

module tlbrr_cell
    import tlbrr_pkg::*;
#(
    parameter int IDX_W      = 6,
    parameter int CELL_INDEX = 0
) (
    input  logic             clk,
    input  logic             rst_n,
    input  tlbrr_cmd_t       cmd,
    input  logic [IDX_W-1:0] force_slot,
    input  tlbrr_tok_t       tok_in,
    input  logic [IDX_W-1:0] slot_in,
    output tlbrr_tok_t       tok_out,
    output logic [IDX_W-1:0] slot_out
);

    logic                 valid_reg, valid_next;
    logic [PAGE_BITS-1:0] frame_reg, frame_next;
    logic [PAGE_BITS-1:0] vpage_reg, vpage_next;
    tlbrr_tok_t           tok_reg, tok_next;
    logic [IDX_W-1:0]     slot_reg, slot_next;
    logic                 hit_fill;
    logic                 hit_force;
    logic                 hit_inval;

    always_comb
    begin
        hit_fill  = 1'b0;
        hit_force = 1'b0;
        hit_inval = 1'b0;
        case (cmd.mode)
            MODE_FILL:  hit_fill  = tok_in.active && !tok_in.done && !valid_reg;
            MODE_FORCE: hit_force = tok_in.active && (force_slot == IDX_W'(CELL_INDEX));
            MODE_INVAL: hit_inval = tok_in.active && (frame_reg == cmd.frame);
            default:    hit_fill  = 1'b0;
        endcase

        valid_next = valid_reg;
        frame_next = frame_reg;
        vpage_next = vpage_reg;
        if (hit_fill || hit_force)
        begin
            valid_next = 1'b1;
            frame_next = cmd.frame;
            vpage_next = cmd.vpage;
        end
        else if (hit_inval)
        begin
            valid_next = 1'b0;
            frame_next = '0;
        end

        tok_next      = tok_in;
        tok_next.done = tok_in.done || hit_fill;
        slot_next     = hit_fill ? IDX_W'(CELL_INDEX) : slot_in;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            frame_reg <= '0;
            tok_reg   <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
            frame_reg <= frame_next;
            tok_reg   <= tok_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        vpage_reg <= vpage_next;
        slot_reg  <= slot_next;
    end

    assign tok_out  = tok_reg;
    assign slot_out = slot_reg;

endmodule
